// File: rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants and width helpers for the ray/sphere intersection core.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 2;

    // width of the signed dot product L.D
    function automatic int dot_width(input int w);
        return 2 * w + 3;
    endfunction

    // width of the square root operand, always even
    function automatic int rad_width(input int w);
        return 4 * w + 6;
    endfunction

endpackage

// File: rtl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Front pipeline: forms L = C - O, the dot and self products, the squared
// projection and the square root operand; flags a miss when it is negative.
// ----------------------------------------------------------------------------
module rsi_front #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_vld,
    input  logic signed [COORD_WIDTH-1:0]                i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]                i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]                i_origin_z,
    input  logic signed [COORD_WIDTH-1:0]                i_dir_x,
    input  logic signed [COORD_WIDTH-1:0]                i_dir_y,
    input  logic signed [COORD_WIDTH-1:0]                i_dir_z,
    input  logic signed [COORD_WIDTH-1:0]                i_center_x,
    input  logic signed [COORD_WIDTH-1:0]                i_center_y,
    input  logic signed [COORD_WIDTH-1:0]                i_center_z,
    input  logic        [COORD_WIDTH-2:0]                i_sphere_radius,
    output logic                                         o_vld,
    output logic                                         o_miss,
    output logic signed [rsi_pkg::dot_width(COORD_WIDTH)-1:0] o_dot,
    output logic        [rsi_pkg::rad_width(COORD_WIDTH)-1:0] o_rad
);
    import rsi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int LW  = W + 1;
    localparam int PW  = LW + W;
    localparam int QW  = 2 * LW;
    localparam int RSW = 2 * (W - 1);
    localparam int DW  = dot_width(W);
    localparam int EW  = 2 * W + 4;
    localparam int H   = W + 1;
    localparam int MW  = 2 * H;
    localparam int RW  = rad_width(W);

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [LW-1:0] r_lx, r_ly, r_lz;
    logic signed [W-1:0]  r_dx, r_dy, r_dz;
    logic        [W-2:0]  r_r;
    logic signed [PW-1:0] r_pdx, r_pdy, r_pdz;
    logic signed [QW-1:0] r_plx, r_ply, r_plz;
    logic       [RSW-1:0] r_rsq2, r_rsq3;
    logic signed [DW-1:0] r_dot3, r_dot4, r_dot5, r_dot6;
    logic signed [EW-1:0] r_ll3, r_e4, r_e5, r_e6;
    logic        [MW-1:0] r_mag;
    logic       [2*H-1:0] r_hh, r_hl, r_lo;
    logic        [RW-1:0] r_sq;
    logic signed [DW-1:0] n_neg;
    logic signed [RW-1:0] n_rad;

    // valid shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // stage 1: origin to center vector
    always_ff @(posedge i_clk) begin
        r_lx <= LW'(i_center_x) - LW'(i_origin_x);
        r_ly <= LW'(i_center_y) - LW'(i_origin_y);
        r_lz <= LW'(i_center_z) - LW'(i_origin_z);
        r_dx <= i_dir_x;
        r_dy <= i_dir_y;
        r_dz <= i_dir_z;
        r_r  <= i_sphere_radius;
    end

    // stage 2: per-axis products and radius squared
    always_ff @(posedge i_clk) begin
        r_pdx  <= r_lx * r_dx;
        r_pdy  <= r_ly * r_dy;
        r_pdz  <= r_lz * r_dz;
        r_plx  <= r_lx * r_lx;
        r_ply  <= r_ly * r_ly;
        r_plz  <= r_lz * r_lz;
        r_rsq2 <= r_r * r_r;
    end

    // stage 3: sums
    always_ff @(posedge i_clk) begin
        r_dot3 <= DW'(r_pdx) + DW'(r_pdy) + DW'(r_pdz);
        r_ll3  <= EW'(r_plx) + EW'(r_ply) + EW'(r_plz);
        r_rsq3 <= r_rsq2;
    end

    // stage 4: L.L - R^2 and magnitude of the projection
    assign n_neg = -r_dot3;

    always_ff @(posedge i_clk) begin
        r_e4   <= r_ll3 - $signed(EW'(r_rsq3));
        r_mag  <= r_dot3[DW-1] ? n_neg[MW-1:0] : r_dot3[MW-1:0];
        r_dot4 <= r_dot3;
    end

    // stage 5: partial products of the projection squared
    always_ff @(posedge i_clk) begin
        r_hh   <= r_mag[MW-1:H] * r_mag[MW-1:H];
        r_hl   <= r_mag[MW-1:H] * r_mag[H-1:0];
        r_lo   <= r_mag[H-1:0] * r_mag[H-1:0];
        r_e5   <= r_e4;
        r_dot5 <= r_dot4;
    end

    // stage 6: recombine the projection squared
    always_ff @(posedge i_clk) begin
        r_sq   <= (RW'(r_hh) << (2 * H)) + (RW'(r_hl) << (H + 1)) + RW'(r_lo);
        r_e6   <= r_e5;
        r_dot6 <= r_dot5;
    end

    // operand of the half chord root; negative means the ray passes by
    assign n_rad  = $signed(r_sq) - ($signed(RW'(r_e6)) <<< (2 * FRAC_BITS));
    assign o_vld  = r_v6;
    assign o_miss = n_rad[RW-1];
    assign o_rad  = n_rad;
    assign o_dot  = r_dot6;

endmodule

// File: rtl/rsi_queue.sv
// ----------------------------------------------------------------------------
// rsi_queue
// Short queue between the front and back pipelines, registered head.
// ----------------------------------------------------------------------------
module rsi_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = rsi_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_vld,
    output logic [DATA_WIDTH-1:0] o_data
);
    import rsi_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]         r_wr, r_rd;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_vld;
    logic                  n_pop;

    // the back end never stalls, so any stored item leaves at once
    assign n_pop   = (r_count != '0);
    assign n_count = r_count + CW'(i_push) - CW'(n_pop);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_vld   = r_vld;

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_vld   <= n_pop;
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (n_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
        end
    end

    // storage write and registered head read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (n_pop) begin
            o_data <= r_mem[r_rd];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !n_pop))
        else $error("push into full queue");
`endif

endmodule

// File: rtl/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back
// Back pipeline: one root bit per stage for the half chord, then near/far
// hit selection, rounding to the output scale and saturation.
// ----------------------------------------------------------------------------
module rsi_back #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_vld,
    input  logic                                               i_miss,
    input  logic signed [rsi_pkg::dot_width(COORD_WIDTH)-1:0]  i_dot,
    input  logic        [rsi_pkg::rad_width(COORD_WIDTH)-1:0]  i_rad,
    output logic                                               o_valid,
    output logic                                               o_hit,
    output logic        [COORD_WIDTH-2:0]                      o_hit_distance
);
    import rsi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = dot_width(W);
    localparam int RW   = rad_width(W);
    localparam int SQW  = RW / 2;
    localparam int REMW = SQW + 2;
    localparam int TW   = DW + 2;
    localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);
    localparam logic [TW-1:0] DMAX = (TW'(1) << (W - 1)) - TW'(1);

    logic [REMW-1:0]      r_rem  [1:SQW-1];
    logic [RW-1:0]        r_rad  [1:SQW-1];
    logic [SQW-1:0]       r_root [1:SQW];
    logic signed [DW-1:0] r_dot  [1:SQW];
    logic                 r_miss [1:SQW];
    logic                 r_vld  [1:SQW];

    logic [TW-2:0] r_t;
    logic          r_hit_e, r_ve;
    logic [TW-1:0] n_t1, n_t2, n_sum, n_shr;

    // root stages, most significant bit first
    for (genvar k = 0; k < SQW; k++) begin : g_root
        logic [REMW-1:0]      a_rem, a_sh, a_trial;
        logic [RW-1:0]        a_rad;
        logic [SQW-1:0]       a_root;
        logic signed [DW-1:0] a_dot;
        logic                 a_miss, a_vld, a_ge;

        if (k == 0) begin : g_in
            assign a_rem  = '0;
            assign a_rad  = i_rad;
            assign a_root = '0;
            assign a_dot  = i_dot;
            assign a_miss = i_miss;
            assign a_vld  = i_vld;
        end else begin : g_mid
            assign a_rem  = r_rem[k];
            assign a_rad  = r_rad[k];
            assign a_root = r_root[k];
            assign a_dot  = r_dot[k];
            assign a_miss = r_miss[k];
            assign a_vld  = r_vld[k];
        end

        // bring down two radicand bits and try the next root bit
        assign a_sh    = {a_rem[REMW-3:0], a_rad[RW-1:RW-2]};
        assign a_trial = {a_root, 2'b01};
        assign a_ge    = (a_sh >= a_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[k+1] <= {a_root[SQW-2:0], a_ge};
            r_dot[k+1]  <= a_dot;
            r_miss[k+1] <= a_miss;
        end

        if (k < SQW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= a_ge ? (a_sh - a_trial) : a_sh;
                r_rad[k+1] <= a_rad << 2;
            end
        end
    end

    // near and far hit distances
    assign n_t1 = TW'(r_dot[SQW]) - TW'(r_root[SQW]);
    assign n_t2 = TW'(r_dot[SQW]) + TW'(r_root[SQW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else begin
            r_ve <= r_vld[SQW];
        end
    end

    // pick the nearest hit not behind the origin
    always_ff @(posedge i_clk) begin
        r_t     <= !n_t1[TW-1] ? n_t1[TW-2:0] : n_t2[TW-2:0];
        r_hit_e <= !r_miss[SQW] && (!n_t1[TW-1] || !n_t2[TW-1]);
    end

    // round half up to the output scale and saturate
    assign n_sum = TW'(r_t) + HALF;
    assign n_shr = n_sum >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit <= r_hit_e;
        if (!r_hit_e) begin
            o_hit_distance <= '0;
        end else if (n_shr > DMAX) begin
            o_hit_distance <= DMAX[W-2:0];
        end else begin
            o_hit_distance <= n_shr[W-2:0];
        end
    end

endmodule

// File: rtl/ray_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Takes one ray/sphere pair per clock while busy is low and returns the
// distance to the nearest hit at or ahead of the ray origin, or a miss.
// Pulse start with an item while busy is low; every item gives exactly one
// result, shown for one cycle with o_valid high, in input order, and the
// result side must take it then. The path runs through six front stages of
// products and sums, the queue write and head register, one stage per half
// chord root bit, then selection and rounding. Busy only rises if the
// internal queue fills, which the free-running back pipeline prevents.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_core #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_z,
    input  logic        [COORD_WIDTH-2:0] i_sphere_radius,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic        [COORD_WIDTH-2:0] o_hit_distance
);
    import rsi_pkg::*;

    localparam int DW = dot_width(COORD_WIDTH);
    localparam int RW = rad_width(COORD_WIDTH);
    localparam int QD = 1 + DW + RW;

    logic                 f_vld, f_miss, q_vld, accept;
    logic signed [DW-1:0] f_dot;
    logic [RW-1:0]        f_rad;
    logic [QD-1:0]        q_data;

    assign accept = start && !busy;

    // front: products, sums and the root operand
    rsi_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (accept),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_sphere_radius (i_sphere_radius),
        .o_vld           (f_vld),
        .o_miss          (f_miss),
        .o_dot           (f_dot),
        .o_rad           (f_rad)
    );

    // queue between front and back
    rsi_queue #(
        .DATA_WIDTH (QD),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  ({f_miss, f_dot, f_rad}),
        .o_full  (busy),
        .o_vld   (q_vld),
        .o_data  (q_data)
    );

    // back: half chord root, selection and rounding
    rsi_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (q_vld),
        .i_miss         (q_data[QD-1]),
        .i_dot          ($signed(q_data[QD-2:RW])),
        .i_rad          (q_data[RW-1:0]),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_hit_distance (o_hit_distance)
    );

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_distance == '0))
        else $error("miss with nonzero distance");
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled although back end drains every cycle");
    a_queue_feeds_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_vld |=> ##1 q_vld)
        else $error("front item did not reach the back end");
`endif

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Ray/sphere intersection core testbench: directed corner rays, then
// constrained-random ray/sphere pairs with a few fully random ones mixed in.
// Every item accepted is scored against a wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW       = rsi_pkg::COORD_WIDTH_DEF;
    localparam int FB       = rsi_pkg::FRAC_BITS_DEF;
    localparam int LATENCY  = 2 * CW + 13;
    localparam int WD_LIMIT = 20 * LATENCY;
    localparam int N_RANDOM = 500;
    localparam int ONE      = 1 << FB;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic [CW-2:0]        rad;
    } t_ray_item;

    typedef struct {
        logic          hit;
        logic [CW-2:0] hit_dist;
    } t_hit_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [CW-1:0] i_dir_x, i_dir_y, i_dir_z;
    logic signed [CW-1:0] i_center_x, i_center_y, i_center_z;
    logic [CW-2:0]        i_sphere_radius;
    logic                 o_valid;
    logic                 o_hit;
    logic [CW-2:0]        o_hit_distance;

    t_ray_item   pending_rays[$];
    t_hit_result expected_hits[$];
    int          err_count = 0;
    int          idle_left = 0;
    int          stall_cycles = 0;

    ray_sphere_intersect_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_origin_z      (i_origin_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_sphere_radius (i_sphere_radius),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_hit_distance  (o_hit_distance)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // exact geometric intersection at wide precision
    function automatic t_hit_result intersect_ray(input t_ray_item r);
        t_wide       lx, ly, lz, tca, ll, perp, rr, rem, thc, cand, t1, t2, t;
        t_wide       dmax;
        t_hit_result res;
        dmax = (t_wide'(1) <<< (CW - 1)) - 1;
        lx = t_wide'(r.cx) - t_wide'(r.ox);
        ly = t_wide'(r.cy) - t_wide'(r.oy);
        lz = t_wide'(r.cz) - t_wide'(r.oz);
        tca = lx * t_wide'(r.dx) + ly * t_wide'(r.dy) + lz * t_wide'(r.dz);
        ll = lx * lx + ly * ly + lz * lz;
        perp = (ll <<< (2 * FB)) - tca * tca;
        rr = (t_wide'({1'b0, r.rad}) * t_wide'({1'b0, r.rad})) <<< (2 * FB);
        res.hit = 1'b0;
        res.hit_dist = '0;
        if (perp > rr) return res;
        rem = rr - perp;
        // bitwise floor root, operand is well under 2^200
        thc = '0;
        for (int b = 99; b >= 0; b--) begin
            cand = thc | (t_wide'(1) <<< b);
            if (cand * cand <= rem) thc = cand;
        end
        t1 = tca - thc;
        t2 = tca + thc;
        if (t1 >= 0) t = t1;
        else if (t2 >= 0) t = t2;
        else return res;
        t = (t + (t_wide'(1) <<< (FB - 1))) >>> FB;
        if (t > dmax) t = dmax;
        res.hit = 1'b1;
        res.hit_dist = t[CW-2:0];
        return res;
    endfunction

    function automatic t_ray_item make_ray(
        input int ox, oy, oz, dx, dy, dz, cx, cy, cz, rad);
        t_ray_item r;
        r.ox = ox; r.oy = oy; r.oz = oz;
        r.dx = dx; r.dy = dy; r.dz = dz;
        r.cx = cx; r.cy = cy; r.cz = cz;
        r.rad = (CW-1)'(rad);
        return r;
    endfunction

    // small signed offset in Q16.16
    function automatic int rand_offset(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // well-formed ray aimed near a sphere, or a fully random pair
    function automatic t_ray_item random_ray();
        t_ray_item r;
        int        dv[3];
        int        o[3];
        int        t, sel, ax;
        if ($urandom_range(3) == 0) begin
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
            r.rad = (CW-1)'($urandom);
            return r;
        end
        dv = '{0, 0, 0};
        sel = $urandom_range(2);
        ax = $urandom_range(2);
        if (sel == 0) begin
            dv[ax] = $urandom_range(1) ? ONE : -ONE;
        end else if (sel == 1) begin
            dv[ax] = $urandom_range(1) ? 46341 : -46341;
            dv[(ax + 1) % 3] = $urandom_range(1) ? 46341 : -46341;
        end else begin
            foreach (dv[k]) dv[k] = $urandom_range(1) ? 37837 : -37837;
        end
        foreach (o[k]) o[k] = rand_offset(1 << 24);
        // distance along the ray, sometimes behind the origin
        t = rand_offset(1 << 22);
        r.ox = o[0]; r.oy = o[1]; r.oz = o[2];
        r.dx = dv[0]; r.dy = dv[1]; r.dz = dv[2];
        r.cx = o[0] + int'((longint'(dv[0]) * t) >>> FB) + rand_offset(1 << 18);
        r.cy = o[1] + int'((longint'(dv[1]) * t) >>> FB) + rand_offset(1 << 18);
        r.cz = o[2] + int'((longint'(dv[2]) * t) >>> FB) + rand_offset(1 << 18);
        r.rad = (CW-1)'($urandom_range(1 << 20));
        return r;
    endfunction

    // driver: present pending items, with random idle bursts early on
    always @(posedge i_clk) begin
        t_ray_item nxt;
        logic      drive;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_hits.push_back(intersect_ray(pending_rays.pop_front()));
            end
            if (start && busy) begin
                drive = 1'b1;
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                drive = 1'b0;
            end else if (pending_rays.size() > 40 && $urandom_range(7) == 0) begin
                idle_left <= $urandom_range(11);
                drive = 1'b0;
            end else begin
                drive = pending_rays.size() > 0;
            end
            start <= drive;
            if (drive) begin
                nxt = pending_rays[0];
                i_origin_x <= nxt.ox; i_origin_y <= nxt.oy; i_origin_z <= nxt.oz;
                i_dir_x    <= nxt.dx; i_dir_y    <= nxt.dy; i_dir_z    <= nxt.dz;
                i_center_x <= nxt.cx; i_center_y <= nxt.cy; i_center_z <= nxt.cz;
                i_sphere_radius <= nxt.rad;
            end
        end
    end

    // monitor: score each result against the oldest prediction
    always @(posedge i_clk) begin
        t_hit_result exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result hit=%0b hit_distance=%h",
                         $time, o_hit, o_hit_distance);
                err_count++;
            end else begin
                exp_r = expected_hits.pop_front();
                if (o_hit !== exp_r.hit) begin
                    $display("%0t: hit mismatch expected %0b actual %0b",
                             $time, exp_r.hit, o_hit);
                    err_count++;
                end
                if (o_hit_distance !== exp_r.hit_dist) begin
                    $display("%0t: hit_distance mismatch expected %h actual %h",
                             $time, exp_r.hit_dist, o_hit_distance);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        i_center_x = '0; i_center_y = '0; i_center_z = '0;
        i_sphere_radius = '0;
        i_rst_n = 1'b0;

        // plain hit ahead, miss to the side, tangent, origin inside
        pending_rays.push_back(make_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE));
        pending_rays.push_back(make_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 5 * ONE, 0, ONE));
        pending_rays.push_back(make_ray(0, 0, 0, 0, ONE, 0, 3 * ONE, 7 * ONE, 0, 3 * ONE));
        pending_rays.push_back(make_ray(ONE, ONE, ONE, 0, 0, -ONE, 0, 0, 0, 5 * ONE));
        // sphere behind the origin
        pending_rays.push_back(make_ray(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, 2 * ONE));
        // zero radius, on the ray and off it
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, ONE, 0, 0, 4 * ONE, 0));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, ONE, 1, 0, 4 * ONE, 0));
        // far sphere: distance saturates
        pending_rays.push_back(make_ray(32'sh8000_0000, 0, 0, ONE, 0, 0,
                                        32'sh7fff_ffff, 0, 0, 1));
        // non-unit directions at the extremes
        pending_rays.push_back(make_ray(0, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        32'sh7fff_ffff, ONE, ONE, ONE, ONE));
        pending_rays.push_back(make_ray(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000,
                                        32'sh8000_0000, -ONE, -ONE, -ONE, ONE));
        // every field at its extremes, then near and at zero
        pending_rays.push_back(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        32'sh7fff_ffff));
        pending_rays.push_back(make_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        32'sh7fff_ffff));
        pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32'sh7fff_ffff));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero direction, inside and outside the sphere
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, 2 * ONE));
        for (int n = 0; n < N_RANDOM; n++) pending_rays.push_back(random_ray());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_rays.size() == 0 && !start && expected_hits.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_count == 0 && expected_hits.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
